@@ hdl/sida_pkg.sv @@
package sida_pkg;

  localparam int MAX_SLOTS_DEF   = 4096;
  localparam int GROW_STEP_DEF   = 1024;
  localparam int HANDLE_BITS_DEF = 32;

  // occupancy is kept as one bit per slot, packed into words
  localparam int WORD_BITS = 32;
  localparam int OFF_BITS  = 5;

  typedef logic [WORD_BITS-1:0] used_word_t;
  typedef logic [11:0]          slot_field_t;
  typedef logic [31:0]          handle_field_t;
  typedef logic [12:0]          count_field_t;
  typedef logic [12:0]          cfg_data_t;
  typedef logic [1:0]           cfg_addr_t;

  localparam cfg_addr_t CFG_INITIAL_SIZE = 2'd0;
  localparam cfg_addr_t CFG_MAX_SIZE     = 2'd1;
  localparam cfg_addr_t CFG_GROW_ENABLE  = 2'd2;

  localparam cfg_data_t INITIAL_SIZE_RST = 13'd64;
  localparam cfg_data_t MAX_SIZE_RST     = 13'd4096;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_SPACE = 2'd1,
    STATUS_EMPTY    = 2'd2,
    STATUS_RANGE    = 2'd3
  } status_t;

  typedef struct packed {
    op_t           op;
    slot_field_t   slot_index;
    handle_field_t entry_handle;
  } in_item_t;

  typedef struct packed {
    status_t       status;
    slot_field_t   result_slot;
    handle_field_t result_handle;
    count_field_t  occupied_count;
    count_field_t  active_size;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_SEEK,
    ST_CHECK,
    ST_REPLY
  } state_t;

  // size registers are saturated to 1..hi where they are used
  function automatic logic [31:0] clamp_size(cfg_data_t v, int unsigned hi);
    logic [31:0] r;
    r = 32'(v);
    if (v == '0) begin
      r = 32'd1;
    end else if (r > 32'(hi)) begin
      r = 32'(hi);
    end
    return r;
  endfunction

endpackage

@@ hdl/sida_ram.sv @@
module sida_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/slot_id_allocator_table.sv @@
// channel  | valid     | stall     | payload
// ---------+-----------+-----------+----------------------------------------
// in       | in_valid  | in_stall  | in_item  (op, slot_index, entry_handle)
// out      | out_valid | out_stall | out_item (status, slot, handle, counts)
// cfg      | cfg_write | -         | cfg_addr, cfg_data
//
// one item at a time; remove and lookup go START, CHECK, REPLY after accept, and
//   START, REPLY when the index is out of range, as do an unused op and a full insert
//   that cannot grow; a searching insert goes START, SEEK, then CHECK per occupancy word
//   read (1 .. MAX_SLOTS/32 + 1), one word per cycle through the read port, then REPLY
// after reset and after each write of initial_size a clearing pass zeroes the
//   occupancy memory word by word, with in_stall high
// in_stall drops in the same cycle that the loaded result appears; a held result does not
//   block the next accept, but that item's reply waits until out_stall lets it load
module slot_id_allocator_table #(
  parameter int MAX_SLOTS   = sida_pkg::MAX_SLOTS_DEF,
  parameter int GROW_STEP   = sida_pkg::GROW_STEP_DEF,
  parameter int HANDLE_BITS = sida_pkg::HANDLE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  sida_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output sida_pkg::out_item_t out_item,
  input  logic                cfg_write,
  input  sida_pkg::cfg_addr_t cfg_addr,
  input  sida_pkg::cfg_data_t cfg_data
);

  localparam int SLOT_W = $clog2(MAX_SLOTS);
  localparam int SIZE_W = $clog2(MAX_SLOTS + 1);
  localparam int OFF_W  = sida_pkg::OFF_BITS;
  localparam int WORDS  = (MAX_SLOTS + sida_pkg::WORD_BITS - 1) / sida_pkg::WORD_BITS;
  localparam int WA_W   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int VIS_W  = $clog2(WORDS + 2);
  localparam int HW     = (HANDLE_BITS < 32) ? HANDLE_BITS : 32;

  sida_pkg::state_t state, state_next;
  logic [WA_W-1:0]  clr_addr, clr_addr_next;
  logic [SIZE_W-1:0] size, size_next;
  logic [SIZE_W-1:0] filled, filled_next;
  logic [SIZE_W-1:0] hint, hint_next;
  sida_pkg::cfg_data_t reg_init, reg_init_next;
  sida_pkg::cfg_data_t reg_max, reg_max_next;
  logic reg_grow, reg_grow_next;
  logic out_valid_next;
  sida_pkg::out_item_t out_item_next;

  sida_pkg::in_item_t item;
  logic [WA_W-1:0]  scan_word, scan_word_next;
  logic [OFF_W-1:0] start_off, start_off_next;
  logic             first, first_next;
  logic [VIS_W-1:0] visits, visits_next;
  sida_pkg::status_t       res_status, res_status_next;
  sida_pkg::slot_field_t   res_slot, res_slot_next;
  sida_pkg::handle_field_t res_handle, res_handle_next;

  logic                 used_we;
  logic [WA_W-1:0]      used_waddr, used_raddr;
  sida_pkg::used_word_t used_wdata, used_rdata;
  logic                 hnd_we;
  logic [SLOT_W-1:0]    hnd_waddr, hnd_raddr;
  logic [HW-1:0]        hnd_wdata, hnd_rdata;

  logic [31:0] init32, max32, lim32, step32, sum32, grow32, lim_word, next_base;
  logic        can_grow;
  logic [SLOT_W-1:0] idx_slot, hint_start, pos_slot;
  logic [WA_W-1:0]   idx_word, next_word;
  logic [OFF_W-1:0]  idx_off, fbit;
  sida_pkg::used_word_t valid_mask, off_mask, free_bits;
  logic found;

  sida_ram #(.WIDTH(sida_pkg::WORD_BITS), .DEPTH(WORDS)) u_used (
    .clk   (clk),
    .we    (used_we),
    .waddr (used_waddr),
    .wdata (used_wdata),
    .raddr (used_raddr),
    .rdata (used_rdata)
  );

  sida_ram #(.WIDTH(HW), .DEPTH(MAX_SLOTS)) u_handle (
    .clk   (clk),
    .we    (hnd_we),
    .waddr (hnd_waddr),
    .wdata (hnd_wdata),
    .raddr (hnd_raddr),
    .rdata (hnd_rdata)
  );

  // growth: double below the step, then add the step, capped at the limit
  always_comb begin
    init32   = sida_pkg::clamp_size(reg_init, MAX_SLOTS);
    max32    = sida_pkg::clamp_size(reg_max, MAX_SLOTS);
    lim32    = (init32 > max32) ? init32 : max32;
    step32   = (32'(size) < 32'(GROW_STEP)) ? 32'(size) : 32'(GROW_STEP);
    sum32    = 32'(size) + step32;
    grow32   = (sum32 > lim32) ? lim32 : sum32;
    can_grow = reg_grow && (32'(size) < lim32);
  end

  // word scan: free slots of the current word inside the active range
  always_comb begin
    idx_slot   = SLOT_W'(item.slot_index);
    idx_word   = WA_W'(idx_slot >> OFF_W);
    idx_off    = OFF_W'(idx_slot);
    hint_start = (32'(hint) >= 32'(size)) ? '0 : SLOT_W'(hint);
    lim_word   = 32'(size) - (32'(scan_word) << OFF_W);
    if (lim_word >= 32'(sida_pkg::WORD_BITS)) begin
      valid_mask = '1;
    end else begin
      valid_mask = (sida_pkg::used_word_t'(1) << lim_word[OFF_W-1:0]) -
                   sida_pkg::used_word_t'(1);
    end
    // first visit of the start word skips slots below the hint
    off_mask  = first ? ~((sida_pkg::used_word_t'(1) << start_off) -
                          sida_pkg::used_word_t'(1)) : '1;
    free_bits = ~used_rdata & valid_mask & off_mask;
    found     = |free_bits;
    fbit      = '0;
    for (int i = sida_pkg::WORD_BITS - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        fbit = OFF_W'(i);
      end
    end
    pos_slot  = SLOT_W'((32'(scan_word) << OFF_W) | 32'(fbit));
    next_base = (32'(scan_word) + 32'd1) << OFF_W;
    next_word = (next_base >= 32'(size)) ? '0 : WA_W'(32'(scan_word) + 32'd1);
  end

  always_comb begin
    state_next      = state;
    clr_addr_next   = clr_addr;
    size_next       = size;
    filled_next     = filled;
    hint_next       = hint;
    reg_init_next   = reg_init;
    reg_max_next    = reg_max;
    reg_grow_next   = reg_grow;
    scan_word_next  = scan_word;
    start_off_next  = start_off;
    first_next      = first;
    visits_next     = visits;
    res_status_next = res_status;
    res_slot_next   = res_slot;
    res_handle_next = res_handle;
    out_item_next   = out_item;
    out_valid_next  = out_valid && out_stall;
    in_stall        = (state != sida_pkg::ST_IDLE);
    used_we         = 1'b0;
    used_waddr      = scan_word;
    used_wdata      = used_rdata;
    used_raddr      = scan_word;
    hnd_we          = 1'b0;
    hnd_waddr       = pos_slot;
    hnd_wdata       = HW'(item.entry_handle);
    hnd_raddr       = idx_slot;

    unique case (state)
      sida_pkg::ST_CLEAR: begin
        used_we    = 1'b1;
        used_waddr = clr_addr;
        used_wdata = '0;
        if (clr_addr == WA_W'(WORDS - 1)) begin
          state_next = sida_pkg::ST_IDLE;
        end else begin
          clr_addr_next = clr_addr + WA_W'(1);
        end
      end
      sida_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = sida_pkg::ST_START;
        end
      end
      sida_pkg::ST_START: begin
        used_raddr      = idx_word;
        res_status_next = sida_pkg::STATUS_OK;
        res_slot_next   = item.slot_index;
        res_handle_next = '0;
        unique case (item.op)
          sida_pkg::OP_INSERT: begin
            res_slot_next = '0;
            if (filled < size) begin
              state_next = sida_pkg::ST_SEEK;
            end else if (can_grow) begin
              size_next  = SIZE_W'(grow32);
              state_next = sida_pkg::ST_SEEK;
            end else begin
              res_status_next = sida_pkg::STATUS_NO_SPACE;
              state_next      = sida_pkg::ST_REPLY;
            end
          end
          sida_pkg::OP_REMOVE, sida_pkg::OP_LOOKUP: begin
            if (32'(item.slot_index) >= 32'(size)) begin
              res_status_next = sida_pkg::STATUS_RANGE;
              state_next      = sida_pkg::ST_REPLY;
            end else begin
              state_next = sida_pkg::ST_CHECK;
            end
          end
          default: begin
            res_slot_next = '0;
            state_next    = sida_pkg::ST_REPLY;
          end
        endcase
      end
      sida_pkg::ST_SEEK: begin
        used_raddr     = WA_W'(hint_start >> OFF_W);
        scan_word_next = WA_W'(hint_start >> OFF_W);
        start_off_next = OFF_W'(hint_start);
        first_next     = 1'b1;
        visits_next    = '0;
        state_next     = sida_pkg::ST_CHECK;
      end
      sida_pkg::ST_CHECK: begin
        if (item.op == sida_pkg::OP_INSERT) begin
          if (found) begin
            used_we       = 1'b1;
            used_waddr    = scan_word;
            used_wdata    = used_rdata | (sida_pkg::used_word_t'(1) << fbit);
            hnd_we        = 1'b1;
            filled_next   = filled + SIZE_W'(1);
            hint_next     = SIZE_W'(pos_slot) + SIZE_W'(1);
            res_slot_next = sida_pkg::slot_field_t'(pos_slot);
            state_next    = sida_pkg::ST_REPLY;
          end else if (visits == VIS_W'(WORDS)) begin
            res_status_next = sida_pkg::STATUS_NO_SPACE;
            res_slot_next   = '0;
            state_next      = sida_pkg::ST_REPLY;
          end else begin
            used_raddr     = next_word;
            scan_word_next = next_word;
            first_next     = 1'b0;
            visits_next    = visits + VIS_W'(1);
          end
        end else if (!used_rdata[idx_off]) begin
          res_status_next = sida_pkg::STATUS_EMPTY;
          state_next      = sida_pkg::ST_REPLY;
        end else if (item.op == sida_pkg::OP_REMOVE) begin
          used_we    = 1'b1;
          used_waddr = idx_word;
          used_wdata = used_rdata & ~(sida_pkg::used_word_t'(1) << idx_off);
          if (filled != '0) begin
            filled_next = filled - SIZE_W'(1);
          end
          if (32'(item.slot_index) < 32'(hint)) begin
            hint_next = SIZE_W'(item.slot_index);
          end
          state_next = sida_pkg::ST_REPLY;
        end else begin
          res_handle_next = sida_pkg::handle_field_t'(hnd_rdata);
          state_next      = sida_pkg::ST_REPLY;
        end
      end
      sida_pkg::ST_REPLY: begin
        if (!out_valid || !out_stall) begin
          out_valid_next               = 1'b1;
          out_item_next.status         = res_status;
          out_item_next.result_slot    = res_slot;
          out_item_next.result_handle  = res_handle;
          out_item_next.occupied_count = sida_pkg::count_field_t'(filled);
          out_item_next.active_size    = sida_pkg::count_field_t'(size);
          state_next                   = sida_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sida_pkg::ST_CLEAR;
      end
    endcase

    // writing initial_size restarts the table
    if (cfg_write) begin
      unique case (cfg_addr)
        sida_pkg::CFG_INITIAL_SIZE: begin
          reg_init_next = cfg_data;
          size_next     = SIZE_W'(sida_pkg::clamp_size(cfg_data, MAX_SLOTS));
          filled_next   = '0;
          hint_next     = '0;
          clr_addr_next = '0;
          state_next    = sida_pkg::ST_CLEAR;
        end
        sida_pkg::CFG_MAX_SIZE: begin
          reg_max_next = cfg_data;
        end
        sida_pkg::CFG_GROW_ENABLE: begin
          reg_grow_next = cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sida_pkg::ST_CLEAR;
      clr_addr  <= '0;
      reg_init  <= sida_pkg::INITIAL_SIZE_RST;
      reg_max   <= sida_pkg::MAX_SIZE_RST;
      reg_grow  <= 1'b0;
      size      <= SIZE_W'(sida_pkg::clamp_size(sida_pkg::INITIAL_SIZE_RST, MAX_SLOTS));
      filled    <= '0;
      hint      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_addr  <= clr_addr_next;
      reg_init  <= reg_init_next;
      reg_max   <= reg_max_next;
      reg_grow  <= reg_grow_next;
      size      <= size_next;
      filled    <= filled_next;
      hint      <= hint_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= in_item;
    end
    scan_word  <= scan_word_next;
    start_off  <= start_off_next;
    first      <= first_next;
    visits     <= visits_next;
    res_status <= res_status_next;
    res_slot   <= res_slot_next;
    res_handle <= res_handle_next;
    out_item   <= out_item_next;
  end

`ifndef NO_ASSERTIONS
  a_filled_le_size: assert property (@(posedge clk) disable iff (rst)
    filled <= size)
    else $error("occupancy above active size");

  a_hint_le_size: assert property (@(posedge clk) disable iff (rst)
    hint <= size)
    else $error("search hint past active size");

  a_size_nonzero: assert property (@(posedge clk) disable iff (rst)
    size != '0)
    else $error("active size is zero");

  a_init_clears: assert property (@(posedge clk) disable iff (rst)
    cfg_write && (cfg_addr == sida_pkg::CFG_INITIAL_SIZE) |=>
      (state == sida_pkg::ST_CLEAR) && (filled == '0) && (hint == '0))
    else $error("initial_size write did not restart the table");

  a_insert_counts: assert property (@(posedge clk) disable iff (rst)
    hnd_we && !cfg_write |=> filled == $past(filled) + SIZE_W'(1))
    else $error("insert did not bump occupancy");
`endif

endmodule
